// ===== rtl/lzw_compressor_12bit_top_assert.svh =====
// ----------------------------------------------------------------------------
// LZW compressor assertion macros
// Shared concurrent assertion forms used by the compressor RTL.
// ----------------------------------------------------------------------------
`ifndef LZW_COMPRESSOR_12BIT_TOP_ASSERT_SVH
`define LZW_COMPRESSOR_12BIT_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LZW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzw assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LZW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzw assertion failed");

`endif

// ===== rtl/lzw_pkg.sv =====
// ----------------------------------------------------------------------------
// LZW compressor package
// Dictionary sizing constants and the structs shared by the cell row.
// ----------------------------------------------------------------------------
package lzw_pkg;

    localparam int DICT_CODES  = 4096;
    localparam int FIRST_CODE  = 256;
    localparam int TABLE_DEPTH = DICT_CODES - FIRST_CODE;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int ENT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CODE_W      = 12;
    localparam int NF_W        = 13;
    localparam int KEY_W       = CODE_W + 8;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ENT_W-1:0]  ent_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [KEY_W-1:0]  key_t;

    // Search result handed from one cell to the next.
    typedef struct packed {
        logic  hit;
        code_t code;
    } link_t;

    // Signals broadcast from the controller to every cell.
    typedef struct packed {
        key_t key;
        ent_t entries;
        logic wr_en;
        idx_t wr_idx;
    } bcast_t;

endpackage

// ===== rtl/lzw_compressor_12bit_top.sv =====
// ----------------------------------------------------------------------------
// LZW compressor, 12-bit codes
// Byte-in LZW coder with a systolic dictionary and a 12-bit code packer.
// ----------------------------------------------------------------------------
// Steps: the first byte of a stream goes from idle straight to decide; every
// other byte first waits in search while the key runs through the row of 3840
// dictionary cells one cell per cycle; then any output bytes go out as taken.
// Throughput: one item at a time; a new item is taken once all bytes are sent.
// Reset: empty dictionary, no prefix, no held nibble; no clearing pass needed.
module lzw_compressor_12bit_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] packed_byte,
    output logic       run_last,
    output logic       stream_done
);

    // Controller states. The search state waits while the key travels the
    // whole cell row; the decide state applies the LZW step and builds the
    // output bytes; the emit state hands them out one byte at a time.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    // Output bytes built for one input item, with the packer state after them.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
        logic            np;
        logic [3:0]      hn;
    } emit_t;

    state_t                  state_reg;
    logic [7:0]              byte_reg;
    logic                    last_reg;
    lzw_pkg::code_t          prefix_reg;
    logic                    pv_reg;
    logic                    np_reg;
    logic [3:0]              hn_reg;
    logic [lzw_pkg::NF_W-1:0] next_free_reg;
    lzw_pkg::idx_t           cnt_reg;
    logic [3:0][7:0]         buf_reg;
    logic [2:0]              n_reg;
    logic [1:0]              idx_reg;
    logic                    out_valid_reg;
    logic [7:0]              packed_byte_reg;
    logic                    run_last_reg;
    logic                    stream_done_reg;

    lzw_pkg::bcast_t bcast;
    lzw_pkg::link_t  links [lzw_pkg::TABLE_DEPTH+1];

    emit_t          emit_next;
    lzw_pkg::code_t prefix_next;
    logic           wr_next;
    logic [1:0]     idx_next;

    // Appends one 12-bit code to the byte stream, high nibble first. An odd
    // code leaves its low nibble held for the next code.
    function automatic emit_t put_code(emit_t s, lzw_pkg::code_t c);
        emit_t r;
        r = s;
        if (s.np)
        begin
            r.bytes[s.n[1:0]]         = {s.hn, c[11:8]};
            r.bytes[s.n[1:0] + 2'd1]  = c[7:0];
            r.n                       = s.n + 3'd2;
            r.np                      = 1'b0;
        end
        else
        begin
            r.bytes[s.n[1:0]] = c[11:4];
            r.n               = s.n + 3'd1;
            r.hn              = c[3:0];
            r.np              = 1'b1;
        end
        return r;
    endfunction

    // Broadcast to the cell row. The key stays stable for the whole search.
    assign bcast.key     = {prefix_reg, byte_reg};
    assign bcast.entries = lzw_pkg::ent_t'(next_free_reg - lzw_pkg::NF_W'(lzw_pkg::FIRST_CODE));
    assign bcast.wr_idx  = lzw_pkg::idx_t'(next_free_reg - lzw_pkg::NF_W'(lzw_pkg::FIRST_CODE));
    assign bcast.wr_en   = (state_reg == ST_DECIDE) && wr_next;

    assign links[0] = '0;

    // The dictionary row: the search result ripples from cell to cell, so the
    // lowest matching code reaches the far end after passing all TABLE_DEPTH cells.
    for (genvar g = 0; g < lzw_pkg::TABLE_DEPTH; g++)
    begin : g_cell
        lzw_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .index    (lzw_pkg::idx_t'(g)),
            .bcast    (bcast),
            .link_in  (links[g]),
            .link_out (links[g+1])
        );
    end

    // One LZW step, using the search result that has reached the row's end.
    always_comb
    begin
        emit_t e;
        e.bytes     = '0;
        e.n         = 3'd0;
        e.np        = np_reg;
        e.hn        = hn_reg;
        wr_next     = 1'b0;
        prefix_next = {4'b0000, byte_reg};
        if (pv_reg)
        begin
            if (links[lzw_pkg::TABLE_DEPTH].hit)
            begin
                prefix_next = links[lzw_pkg::TABLE_DEPTH].code;
            end
            else
            begin
                e       = put_code(e, prefix_reg);
                wr_next = (next_free_reg < lzw_pkg::NF_W'(lzw_pkg::DICT_CODES));
            end
        end
        if (last_reg)
        begin
            e = put_code(e, prefix_next);
            if (e.np)
            begin
                e.bytes[e.n[1:0]] = {e.hn, 4'b0000};
                e.n               = e.n + 3'd1;
            end
        end
        emit_next = e;
    end

    assign idx_next = idx_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prefix_reg      <= '0;
            pv_reg          <= 1'b0;
            np_reg          <= 1'b0;
            hn_reg          <= '0;
            next_free_reg   <= lzw_pkg::NF_W'(lzw_pkg::FIRST_CODE);
            cnt_reg         <= '0;
            n_reg           <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
            run_last_reg    <= 1'b0;
            stream_done_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= pv_reg ? ST_SEARCH : ST_DECIDE;
                    end
                end
                ST_SEARCH:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == lzw_pkg::idx_t'(lzw_pkg::TABLE_DEPTH - 1))
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (last_reg)
                    begin
                        prefix_reg    <= '0;
                        pv_reg        <= 1'b0;
                        np_reg        <= 1'b0;
                        hn_reg        <= '0;
                        next_free_reg <= lzw_pkg::NF_W'(lzw_pkg::FIRST_CODE);
                    end
                    else
                    begin
                        prefix_reg <= prefix_next;
                        pv_reg     <= 1'b1;
                        np_reg     <= emit_next.np;
                        hn_reg     <= emit_next.hn;
                        if (wr_next)
                        begin
                            next_free_reg <= next_free_reg + 1'b1;
                        end
                    end
                    n_reg   <= emit_next.n;
                    idx_reg <= '0;
                    if (emit_next.n != 3'd0)
                    begin
                        out_valid_reg   <= 1'b1;
                        run_last_reg    <= (emit_next.n == 3'd1);
                        stream_done_reg <= last_reg && (emit_next.n == 3'd1);
                        state_reg       <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        if (run_last_reg)
                        begin
                            out_valid_reg   <= 1'b0;
                            run_last_reg    <= 1'b0;
                            stream_done_reg <= 1'b0;
                            state_reg       <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg         <= idx_next;
                            run_last_reg    <= ({1'b0, idx_next} == n_reg - 3'd1);
                            stream_done_reg <= last_reg
                                               && ({1'b0, idx_next} == n_reg - 3'd1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers: the accepted item and the bytes waiting to go out.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            byte_reg <= data_byte;
            last_reg <= end_of_input;
        end
        if (state_reg == ST_DECIDE)
        begin
            buf_reg         <= emit_next.bytes;
            packed_byte_reg <= emit_next.bytes[0];
        end
        else if ((state_reg == ST_EMIT) && out_ready && !run_last_reg)
        begin
            packed_byte_reg <= buf_reg[idx_next];
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign packed_byte = packed_byte_reg;
    assign run_last    = run_last_reg;
    assign stream_done = stream_done_reg;

    `include "lzw_compressor_12bit_top_assert.svh"

    // Input and output never handshake in the same cycle of one item.
    `LZW_ASSERT_NOW(a_no_overlap, in_ready, !out_valid)
    // The code counter never runs past the dictionary size.
    `LZW_ASSERT_NOW(a_free_range, 1'b1, next_free_reg <= lzw_pkg::NF_W'(lzw_pkg::DICT_CODES))
    // The closing byte of a stream is also the closing byte of its item.
    `LZW_ASSERT_NOW(a_done_last, out_valid && stream_done, run_last)
    // After the last byte of an item is taken the output goes quiet.
    `LZW_ASSERT_NEXT(a_last_drain, out_valid && out_ready && run_last, !out_valid)

endmodule

// ===== rtl/lzw_cell.sv =====
// ----------------------------------------------------------------------------
// LZW dictionary cell
// Holds one learned pair and forwards the running search result.
// ----------------------------------------------------------------------------
module lzw_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  lzw_pkg::idx_t   index,
    input  lzw_pkg::bcast_t bcast,
    input  lzw_pkg::link_t  link_in,
    output lzw_pkg::link_t  link_out
);

    lzw_pkg::key_t  entry_reg;
    lzw_pkg::link_t link_reg;
    lzw_pkg::link_t link_next;
    logic           match;
    lzw_pkg::code_t my_code;

    assign my_code = lzw_pkg::code_t'(lzw_pkg::FIRST_CODE) + lzw_pkg::code_t'(index);

    // Only entries below the fill count take part in a search.
    assign match = (entry_reg == bcast.key)
                   && (lzw_pkg::ent_t'(index) < bcast.entries);

    always_comb
    begin
        link_next.hit  = link_in.hit | match;
        link_next.code = link_in.hit ? link_in.code : (match ? my_code : link_in.code);
    end

    always_ff @(posedge clk)
    begin
        if (bcast.wr_en && (bcast.wr_idx == index))
        begin
            entry_reg <= bcast.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule
